// ----- rtl/crrs_pkg.sv -----
// Shared types and constants of the CAN receive router and bus supervisor.
// Used by the route cell, the route chain and the top level; no dependencies.
`timescale 1ns / 1ps
package crrs_pkg;

	localparam int ROUTES_PER_BUS = 16;
	localparam int BUSES          = 3;

	// Fixed field widths of the item, result and configuration ports.
	localparam int ID_W           = 11;
	localparam int TICK_W         = 32;
	localparam int BUS_IN_W       = 2;
	localparam int ROUTE_SLOT_W   = 4;
	localparam int MASK_W         = 3;
	localparam int CFG_W          = 32;
	localparam int PADDR_W        = 3;

	// Widths that follow from the table sizes.
	localparam int SLOT_W = (ROUTES_PER_BUS > 1) ? $clog2(ROUTES_PER_BUS) : 1;
	localparam int CNT_W  = $clog2(ROUTES_PER_BUS + 1);
	localparam int BUS_W  = (BUSES > 1) ? $clog2(BUSES) : 1;

	// Register indexes, taken from the word address.
	localparam logic REG_DEAD_TIMEOUT = 1'b0;
	localparam logic REG_REINIT       = 1'b1;

	localparam logic [CFG_W-1:0] DEAD_TIMEOUT_RST = 32'd100;
	localparam logic [CFG_W-1:0] REINIT_RST       = 32'd100;

	typedef enum logic [1:0] {
		OP_REG    = 2'd0,
		OP_RX     = 2'd1,
		OP_BUSOFF = 2'd2,
		OP_POLL   = 2'd3
	} op_t;

	// Search token that walks the row of route cells, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              is_reg;
		logic [BUS_W-1:0]  bus;
		logic [ID_W-1:0]   id;
		logic [CNT_W-1:0]  count;
		logic [SLOT_W-1:0] pos;
		logic              hit;
		logic              wr;
		logic [SLOT_W-1:0] slot;
	} tok_t;

	// Per-bus vector fitted to the width of the mask fields.
	function automatic logic [MASK_W-1:0] fit_mask(input logic [BUSES-1:0] v);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < BUSES) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/can_rx_router_supervisor_top.sv -----
// Top level of the CAN receive router and bus supervisor.
// Depends on crrs_pkg and crrs_route_chain.
`timescale 1ns / 1ps
//
// Items arrive on the request channel (req_valid, req_stall) and each gives
// exactly one result on the response channel (rsp_valid, rsp_stall). A
// transfer happens at a rising edge where valid is high and stall is low.
// One item is worked on at a time; req_stall is high while it is in hand.
// Route registration and received frames send a search token through a row
// of sixteen route cells, one cell per cycle, and its outcome is captured
// in the item registers before the result register. Bus-off events, polls
// and items for a bus that does not exist skip the row. Either way the next
// item can be taken as soon as the result appears. The result register
// is the only output stage: while the receiver stalls it holds the result,
// and a finished item waits for it to be taken before its result and state
// updates are committed.
// Reset clears the route counts, bus state and timers and sets both
// timeout registers to 100; the identifier tables need no clearing.
// The APB port takes writes of dead_timeout_ms at 0x0 and reinit_interval_ms
// at 0x4; the user must make them only while no item is in hand, as the
// block does not enforce this. pready is always high.
module can_rx_router_supervisor_top import crrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// Request channel.
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              op,
	input  logic [BUS_IN_W-1:0]     bus,
	input  logic [ID_W-1:0]         can_id,
	input  logic [TICK_W-1:0]       now_ms,
	input  logic                    silence_check,
	// Response channel.
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic                    ok,
	output logic [ROUTE_SLOT_W-1:0] route_slot,
	output logic [MASK_W-1:0]       stop_mask,
	output logic [MASK_W-1:0]       restart_mask,
	output logic [MASK_W-1:0]       dead_mask,
	output logic                    all_online,
	// Configuration port.
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [CFG_W-1:0]        pwdata,
	output logic [CFG_W-1:0]        prdata,
	output logic                    pready
);

	// Configuration registers.
	logic [CFG_W-1:0] dead_timeout_q;
	logic [CFG_W-1:0] reinit_q;

	// Per-bus supervisor state.
	logic [CNT_W-1:0]  count_q [BUSES];
	logic [BUSES-1:0]  dead_q;
	logic [BUSES-1:0]  traffic_q;
	logic [TICK_W-1:0] silence_q [BUSES];
	logic [TICK_W-1:0] last_reinit_q [BUSES];

	// Item in hand.
	logic              busy_q;
	logic              scan_wait_q;
	op_t               op_q;
	logic              bus_ok_q;
	logic [BUS_W-1:0]  bidx_q;
	logic [TICK_W-1:0] now_q;
	logic              expect_q;
	logic              hit_q;
	logic              wr_q;
	logic [SLOT_W-1:0] slot_q;

	// Result register.
	logic                    rsp_valid_q;
	logic                    ok_q;
	logic [ROUTE_SLOT_W-1:0] slot_out_q;
	logic [MASK_W-1:0]       stop_q;
	logic [MASK_W-1:0]       restart_q;
	logic [MASK_W-1:0]       dead_out_q;
	logic                    online_q;

	logic              accept;
	logic              bus_ok;
	logic [BUS_W-1:0]  bidx;
	logic              needs_scan;
	logic              finish;
	logic              cfg_wr;
	tok_t              chain_in;
	tok_t              chain_out;

	// Next state and result of the item in hand.
	logic [CNT_W-1:0]  count_n [BUSES];
	logic [BUSES-1:0]  dead_n;
	logic [BUSES-1:0]  traffic_n;
	logic [TICK_W-1:0] silence_n [BUSES];
	logic [TICK_W-1:0] last_reinit_n [BUSES];
	logic              res_ok;
	logic [SLOT_W-1:0] res_slot;
	logic [BUSES-1:0]  res_stop;
	logic [BUSES-1:0]  res_restart;
	logic              res_online;
	logic              count_in_range;

	// Request side decode.
	assign accept     = req_valid && !req_stall;
	assign req_stall  = busy_q;
	assign bus_ok     = int'(bus) < BUSES;
	assign bidx       = BUS_W'(bus);
	assign needs_scan = bus_ok && ((op_t'(op) == OP_REG) || (op_t'(op) == OP_RX));
	assign finish     = busy_q && !scan_wait_q && (!rsp_valid_q || !rsp_stall);
	assign cfg_wr     = psel && penable && pwrite && pready;

	// Launch the search token straight from the request ports.
	always_comb begin
		chain_in        = '0;
		chain_in.valid  = accept && needs_scan;
		chain_in.is_reg = op_t'(op) == OP_REG;
		chain_in.bus    = bidx;
		chain_in.id     = can_id;
		chain_in.count  = bus_ok ? count_q[bidx] : '0;
	end

	crrs_route_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (chain_in),
		.tok_out (chain_out)
	);

	// Result and state update of the item in hand.
	always_comb begin
		logic              changed;
		logic              dead_v;
		logic [TICK_W-1:0] since_reinit;
		logic [TICK_W-1:0] since_silence;
		changed       = 1'b0;
		dead_v        = 1'b0;
		since_reinit  = '0;
		since_silence = '0;
		count_n       = count_q;
		dead_n        = dead_q;
		traffic_n     = traffic_q;
		silence_n     = silence_q;
		last_reinit_n = last_reinit_q;
		res_ok        = 1'b0;
		res_slot      = '0;
		res_stop      = '0;
		res_restart   = '0;
		res_online    = 1'b0;
		case (op_q)
			OP_REG: begin
				if (bus_ok_q && wr_q) begin
					res_ok           = 1'b1;
					res_slot         = slot_q;
					count_n[bidx_q]  = count_q[bidx_q] + CNT_W'(1);
				end
			end
			OP_RX: begin
				if (bus_ok_q) begin
					traffic_n[bidx_q] = 1'b1;
					if (hit_q) begin
						res_ok   = 1'b1;
						res_slot = slot_q;
					end
				end
			end
			OP_BUSOFF: begin
				if (bus_ok_q) begin
					res_stop[bidx_q] = 1'b1;
					dead_n[bidx_q]   = 1'b1;
					res_ok           = 1'b1;
				end
			end
			OP_POLL: begin
				// Each bus is judged on its own state only.
				for (int b = 0; b < BUSES; b++) begin
					changed       = traffic_q[b];
					dead_v        = dead_q[b] && !changed;
					since_reinit  = now_q - last_reinit_q[b];
					since_silence = now_q - silence_q[b];
					if (dead_v && (since_reinit >= reinit_q)) begin
						res_stop[b]      = 1'b1;
						res_restart[b]   = 1'b1;
						last_reinit_n[b] = now_q;
					end
					if (!expect_q || changed) begin
						traffic_n[b] = 1'b0;
						silence_n[b] = now_q;
					end else if (since_silence > dead_timeout_q) begin
						dead_v = 1'b1;
					end
					dead_n[b] = dead_v;
				end
				res_online = !(|dead_n);
			end
			default: begin
			end
		endcase
	end

	// Item control, scan capture and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			scan_wait_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q      <= 1'b1;
				scan_wait_q <= needs_scan;
			end else begin
				if (chain_out.valid) begin
					scan_wait_q <= 1'b0;
				end
				if (finish) begin
					busy_q <= 1'b0;
				end
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the item in hand and of the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(op);
			bus_ok_q <= bus_ok;
			bidx_q   <= bidx;
			now_q    <= now_ms;
			expect_q <= silence_check;
			hit_q    <= 1'b0;
			wr_q     <= 1'b0;
			slot_q   <= '0;
		end else if (chain_out.valid) begin
			hit_q  <= chain_out.hit;
			wr_q   <= chain_out.wr;
			slot_q <= chain_out.slot;
		end
		if (finish) begin
			ok_q       <= res_ok;
			slot_out_q <= ROUTE_SLOT_W'(res_slot);
			stop_q     <= fit_mask(res_stop);
			restart_q  <= fit_mask(res_restart);
			dead_out_q <= fit_mask(dead_n);
			online_q   <= res_online;
		end
	end

	// Supervisor state is committed when the item's result is stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q    <= '0;
			traffic_q <= '0;
			for (int b = 0; b < BUSES; b++) begin
				count_q[b]       <= '0;
				silence_q[b]     <= '0;
				last_reinit_q[b] <= '0;
			end
		end else if (finish) begin
			dead_q        <= dead_n;
			traffic_q     <= traffic_n;
			count_q       <= count_n;
			silence_q     <= silence_n;
			last_reinit_q <= last_reinit_n;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_timeout_q <= DEAD_TIMEOUT_RST;
			reinit_q       <= REINIT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DEAD_TIMEOUT: dead_timeout_q <= pwdata;
				REG_REINIT:       reinit_q       <= pwdata;
				default: begin
				end
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_REINIT) ? reinit_q : dead_timeout_q;
	assign pready = 1'b1;

	assign rsp_valid    = rsp_valid_q;
	assign ok           = ok_q;
	assign route_slot   = slot_out_q;
	assign stop_mask    = stop_q;
	assign restart_mask = restart_q;
	assign dead_mask    = dead_out_q;
	assign all_online   = online_q;

	// Route counts never pass the table size.
	always_comb begin
		count_in_range = 1'b1;
		for (int b = 0; b < BUSES; b++) begin
			if (count_q[b] > CNT_W'(ROUTES_PER_BUS)) begin
				count_in_range = 1'b0;
			end
		end
	end

	// A token only leaves the row while its item waits for it.
	a_token_expected: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.valid |-> scan_wait_q)
		else $error("search token left the route row with no scan pending");

	// A scan is only pending for an item in hand.
	a_scan_in_hand: assert property (@(posedge clk) disable iff (!arst_n)
		scan_wait_q |-> busy_q)
		else $error("scan pending with no item in hand");

	// A transfer on the request side always leaves an item in hand.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> busy_q)
		else $error("accepted item was not taken in hand");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_in_range)
		else $error("route count exceeds table size");

endmodule

// ----- rtl/crrs_cell.sv -----
// One route cell: holds one slot of every bus's identifier table.
// Depends on crrs_pkg for the token type and widths.
`timescale 1ns / 1ps
module crrs_cell import crrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic [ID_W-1:0] ids_q [BUSES];
	tok_t            tok_q;
	tok_t            tok_nxt;
	logic            in_use;
	logic            match;
	logic            do_wr;

	// Compare against the stored identifier, or claim the first free slot.
	always_comb begin
		in_use  = CNT_W'(tok_in.pos) < tok_in.count;
		match   = in_use && (ids_q[tok_in.bus] == tok_in.id);
		do_wr   = tok_in.valid && tok_in.is_reg && !tok_in.hit
			&& (CNT_W'(tok_in.pos) == tok_in.count);
		tok_nxt = tok_in;
		tok_nxt.pos = tok_in.pos + SLOT_W'(1);
		if (tok_in.valid && match && !tok_in.hit) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.slot = tok_in.pos;
		end
		if (do_wr) begin
			tok_nxt.wr   = 1'b1;
			tok_nxt.slot = tok_in.pos;
		end
	end

	// Identifier storage needs no reset: only slots below the count are read.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ids_q[tok_in.bus] <= tok_in.id;
		end
	end

	// The token moves on to the next cell every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/crrs_route_chain.sv -----
// Row of route cells, one per slot, through which the search token passes.
// Depends on crrs_pkg and crrs_cell.
`timescale 1ns / 1ps
module crrs_route_chain import crrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	tok_t link [ROUTES_PER_BUS + 1];

	assign link[0] = tok_in;

	// Cell k holds slot k; the token leaves the last cell after one full pass.
	for (genvar k = 0; k < ROUTES_PER_BUS; k++) begin : g_cell
		crrs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (link[k]),
			.tok_out (link[k+1])
		);
	end

	assign tok_out = link[ROUTES_PER_BUS];

endmodule
